// ===== rtl/nrsc_pkg.sv =====
// shared constants, types and codes for the note row span coalescer
// no dependencies; every other file of the block but nrsc_ram imports this package
package nrsc_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int NOTE_COUNT = 128;
  localparam int PIXEL_BITS = 16;

  localparam int NOTE_W   = $clog2(NOTE_COUNT);
  localparam int HEIGHT_W = 6;
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W    = HEIGHT_W + 1;
  localparam int FUNC_W   = 2;
  localparam int RAM_W    = 2 * PIXEL_BITS;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // input function codes
  localparam logic [FUNC_W-1:0] FUNC_SPAN  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

  // register map
  localparam logic [PADDR_W-3:0] REG_HEIGHT = 1'd0;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 6'd63;

  typedef struct packed {
    logic             we;
    logic [ROW_W-1:0] waddr;
    logic [RAM_W-1:0] wdata;
    logic             re;
    logic [ROW_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== rtl/nrsc_span_if.sv =====
// valid/ready channel carrying one input transaction (span, clear or flush)
// depends on nrsc_pkg
interface nrsc_span_if import nrsc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic [NOTE_W-1:0]     note;
  logic [PIXEL_BITS-1:0] span_start;
  logic [PIXEL_BITS-1:0] span_end;

  modport source (output valid, func, note, span_start, span_end, input ready);
  modport sink   (input valid, func, note, span_start, span_end, output ready);
endinterface

// ===== rtl/nrsc_line_if.sv =====
// valid/ready channel carrying one emitted line transaction
// depends on nrsc_pkg
interface nrsc_line_if import nrsc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [HEIGHT_W-1:0]   line_row;
  logic [PIXEL_BITS-1:0] line_start;
  logic [PIXEL_BITS-1:0] line_end;
  logic                  last;

  modport source (output valid, line_row, line_start, line_end, last, input ready);
  modport sink   (input valid, line_row, line_start, line_end, last, output ready);
endinterface

// ===== rtl/nrsc_ram.sv =====
// generic single write port, single read port ram with registered read data
// no package dependencies; read data holds while no read is issued
module nrsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/nrsc_cfg.sv =====
// apb-style register port holding the display height
// depends on nrsc_pkg
module nrsc_cfg import nrsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  output logic [HEIGHT_W-1:0] height_o
);

  logic [HEIGHT_W-1:0] height_q, height_d;
  logic                hit;

  // byte address 4*i selects register i
  assign hit = (paddr[PADDR_W-1:2] == REG_HEIGHT);

  always_comb begin
    height_d = height_q;
    if (psel && penable && pwrite && hit) begin
      height_d = pwdata[HEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HEIGHT_RESET;
    end else begin
      height_q <= height_d;
    end
  end

  assign prdata   = hit ? PDATA_W'(height_q) : '0;
  assign pready   = 1'b1;
  assign height_o = height_q;

endmodule

// ===== rtl/nrsc_ctrl.sv =====
// sequencer: note to row mapping, row read-modify-write, clear, flush walk
// and the output register; depends on nrsc_pkg and the two channel interfaces
module nrsc_ctrl import nrsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  nrsc_span_if.sink           span,
  nrsc_line_if.source         line,
  input  logic [HEIGHT_W-1:0] height_i,
  output ram_req_t            ram_req_o,
  input  logic [RAM_W-1:0]    ram_rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SPAN,
    S_FL_RD,
    S_FL_EMIT
  } state_e;

  state_e                state_q, state_d;
  logic [MAX_ROWS-1:0]   valid_q, valid_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [PIXEL_BITS-1:0] s_q, s_d, e_q, e_d;
  logic [CNT_W-1:0]      k_q, k_d;
  logic [HEIGHT_W-1:0]   limit_q, limit_d;
  logic                  out_valid_q, out_valid_d;
  logic [HEIGHT_W-1:0]   out_row_q, out_row_d;
  logic [PIXEL_BITS-1:0] out_start_q, out_start_d, out_end_q, out_end_d;
  logic                  out_last_q, out_last_d;

  logic                         in_acc, out_free;
  logic [NOTE_W+HEIGHT_W-1:0]   map_prod, map_sum;
  logic [HEIGHT_W-1:0]          map_row, flush_limit;
  logic                         row_ok;
  logic [PIXEL_BITS-1:0]        old_s, old_e;
  logic                         touch, more_after;

  assign in_acc   = span.valid && span.ready;
  assign out_free = !out_valid_q || line.ready;

  // row = h - ceil(note*h/NOTE_COUNT)
  assign map_prod = (NOTE_W+HEIGHT_W)'(span.note) * (NOTE_W+HEIGHT_W)'(height_i);
  assign map_sum  = map_prod + (NOTE_W+HEIGHT_W)'(NOTE_COUNT - 1);
  assign map_row  = height_i - map_sum[NOTE_W+HEIGHT_W-1:NOTE_W];
  assign row_ok   = CNT_W'(map_row) < CNT_W'(MAX_ROWS);

  assign flush_limit = (height_i > HEIGHT_W'(MAX_ROWS - 1)) ? HEIGHT_W'(MAX_ROWS - 1)
                                                            : height_i;

  assign old_s = ram_rdata_i[RAM_W-1:PIXEL_BITS];
  assign old_e = ram_rdata_i[PIXEL_BITS-1:0];

  // overlapping or adjacent spans (no pixel gap), compared one bit wider to avoid wrap
  assign touch = !(({1'b0, old_e} + 1'b1) < {1'b0, s_q}) &&
                 !({1'b0, old_s} > ({1'b0, e_q} + 1'b1));

  // any valid row after the current one still inside the flush range
  always_comb begin
    more_after = 1'b0;
    for (int j = 0; j < MAX_ROWS; j++) begin
      if (valid_q[j] && (CNT_W'(j) > k_q) && (CNT_W'(j) <= CNT_W'(limit_q))) begin
        more_after = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    row_d       = row_q;
    s_d         = s_q;
    e_d         = e_q;
    k_d         = k_q;
    limit_d     = limit_q;
    out_valid_d = out_valid_q && !line.ready;
    out_row_d   = out_row_q;
    out_start_d = out_start_q;
    out_end_d   = out_end_q;
    out_last_d  = out_last_q;
    ram_req_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (span.func)
            FUNC_SPAN: begin
              if (row_ok) begin
                row_d           = map_row[ROW_W-1:0];
                s_d             = span.span_start;
                e_d             = span.span_end;
                ram_req_o.re    = 1'b1;
                ram_req_o.raddr = map_row[ROW_W-1:0];
                state_d         = S_SPAN;
              end
            end
            FUNC_CLEAR: begin
              valid_d = '0;
            end
            FUNC_FLUSH: begin
              k_d     = '0;
              limit_d = flush_limit;
              state_d = S_FL_RD;
            end
            default: begin
            end
          endcase
        end
      end

      S_SPAN: begin
        ram_req_o.waddr = row_q;
        if (!valid_q[row_q]) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.wdata = {s_q, e_q};
          valid_d[row_q]  = 1'b1;
          state_d         = S_IDLE;
        end else if (touch) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.wdata = {((s_q < old_s) ? s_q : old_s), ((e_q > old_e) ? e_q : old_e)};
          state_d         = S_IDLE;
        end else if (out_free) begin
          // pending span leaves as a line, the new one takes the row
          out_valid_d     = 1'b1;
          out_row_d       = HEIGHT_W'(row_q);
          out_start_d     = old_s;
          out_end_d       = old_e;
          out_last_d      = 1'b1;
          ram_req_o.we    = 1'b1;
          ram_req_o.wdata = {s_q, e_q};
          state_d         = S_IDLE;
        end
      end

      S_FL_RD: begin
        if (k_q > CNT_W'(limit_q)) begin
          state_d = S_IDLE;
        end else if (valid_q[k_q[ROW_W-1:0]]) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = k_q[ROW_W-1:0];
          state_d         = S_FL_EMIT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      S_FL_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_row_d   = HEIGHT_W'(k_q);
          out_start_d = old_s;
          out_end_d   = old_e;
          out_last_d  = !more_after;
          k_d         = k_q + 1'b1;
          state_d     = S_FL_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      row_q       <= '0;
      s_q         <= '0;
      e_q         <= '0;
      k_q         <= '0;
      limit_q     <= '0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_start_q <= '0;
      out_end_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      row_q       <= row_d;
      s_q         <= s_d;
      e_q         <= e_d;
      k_q         <= k_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
      out_row_q   <= out_row_d;
      out_start_q <= out_start_d;
      out_end_q   <= out_end_d;
      out_last_q  <= out_last_d;
    end
  end

  assign span.ready      = (state_q == S_IDLE);
  assign line.valid      = out_valid_q;
  assign line.line_row   = out_row_q;
  assign line.line_start = out_start_q;
  assign line.line_end   = out_end_q;
  assign line.last       = out_last_q;

`ifndef ASSERT_OFF
  a_no_rd_wr_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req_o.we && ram_req_o.re))
    else $error("row memory read and write in the same cycle");

  a_flush_emits_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FL_EMIT) |-> valid_q[k_q[ROW_W-1:0]])
    else $error("flush about to emit an empty row");

  a_flush_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FL_RD || state_q == S_FL_EMIT) |-> (k_q <= CNT_W'(limit_q) + 1'b1))
    else $error("flush row counter ran past the range");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && span.func == FUNC_CLEAR) |=> (valid_q == '0))
    else $error("clear left a row valid");
`endif

endmodule

// ===== rtl/note_row_span_coalescer.sv =====
// span: accept in idle, then read-modify-write in S_SPAN on the registered row
// memory read data; a replaced span leaves as a line via the output register, and
// S_SPAN waits while that register is full; clear and unknown codes end at accept;
// flush emits each valid row in 0..min(height, rows-1); a stalled line output holds it
// reset clears the row valid flops and sets height to 63; the row memory is
// not swept, its entries are used only behind a set valid bit
module note_row_span_coalescer import nrsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  nrsc_span_if.sink          in_span,
  nrsc_line_if.source        out_line,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [HEIGHT_W-1:0] height;
  ram_req_t            ram_req;
  logic [RAM_W-1:0]    ram_rdata;

  nrsc_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .height_o (height)
  );

  nrsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .span        (in_span),
    .line        (out_line),
    .height_i    (height),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // per-row pending span, {start, end}
  nrsc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== sim/tb_note_row_span_coalescer.sv =====
// self-checking testbench for note_row_span_coalescer: directed table, then random
// phases at several heights and handshake pressure mixes; depends on nrsc_pkg,
// nrsc_span_if, nrsc_line_if and the rtl top level
module tb_note_row_span_coalescer import nrsc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int LIMIT  = 300000;
  localparam int SETTLE = 150;  // margin for the worst flush walk over every row and every line
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 19;

  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [NOTE_W-1:0]     note;
    logic [PIXEL_BITS-1:0] s;
    logic [PIXEL_BITS-1:0] e;
  } span_item_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0]   row;
    logic [PIXEL_BITS-1:0] lo;
    logic [PIXEL_BITS-1:0] hi;
    logic                  last;
  } line_t;

  typedef struct packed {
    span_item_t item;
    bit         typed;     // expectation written out below
    bit         has_line;  // typed row emits exactly one line
    line_t      want;
  } stim_row_t;

  localparam line_t NO_LINE = '0;

  // reset height 63: note 0 -> row 63, note 64 -> row 31, note 127/126 -> row 0, note 1 -> row 62
  localparam int DIR_N = 18;
  localparam stim_row_t DIR_TBL [DIR_N] = '{
    '{'{FUNC_SPAN,   7'd0,   16'd0,      16'd10},     1'b1, 1'b0, NO_LINE},
    '{'{FUNC_SPAN,   7'd0,   16'd11,     16'd20},     1'b1, 1'b0, NO_LINE},
    '{'{FUNC_SPAN,   7'd0,   16'd22,     16'd30},     1'b1, 1'b1,
      '{6'd63, 16'd0, 16'd20, 1'b1}},
    '{'{FUNC_SPAN,   7'd127, 16'hFFFF,   16'hFFFF},   1'b1, 1'b0, NO_LINE},
    '{'{FUNC_SPAN,   7'd127, 16'd0,      16'hFFFE},   1'b1, 1'b0, NO_LINE},
    '{'{FUNC_SPAN,   7'd127, 16'd0,      16'd0},      1'b1, 1'b0, NO_LINE},
    '{'{FUNC_SPAN,   7'd64,  16'd100,    16'd50},     1'b1, 1'b0, NO_LINE},
    '{'{FUNC_SPAN,   7'd64,  16'd52,     16'd60},     1'b1, 1'b1,
      '{6'd31, 16'd100, 16'd50, 1'b1}},
    '{'{FUNC_SPAN,   7'd64,  16'd40,     16'd51},     1'b0, 1'b0, NO_LINE},
    '{'{FUNC_UNUSED, 7'd127, 16'hFFFF,   16'hFFFF},   1'b1, 1'b0, NO_LINE},
    '{'{FUNC_FLUSH,  7'd0,   16'd0,      16'd0},      1'b0, 1'b0, NO_LINE},
    '{'{FUNC_FLUSH,  7'd0,   16'd0,      16'd0},      1'b0, 1'b0, NO_LINE},
    '{'{FUNC_CLEAR,  7'd0,   16'd0,      16'd0},      1'b1, 1'b0, NO_LINE},
    '{'{FUNC_FLUSH,  7'd0,   16'd0,      16'd0},      1'b1, 1'b0, NO_LINE},
    '{'{FUNC_SPAN,   7'd1,   16'h5555,   16'hAAAA},   1'b1, 1'b0, NO_LINE},
    '{'{FUNC_SPAN,   7'd126, 16'hAAAA,   16'h5555},   1'b0, 1'b0, NO_LINE},
    '{'{FUNC_SPAN,   7'd1,   16'd0,      16'd0},      1'b1, 1'b1,
      '{6'd62, 16'h5555, 16'hAAAA, 1'b1}},
    '{'{FUNC_FLUSH,  7'd0,   16'd0,      16'd0},      1'b0, 1'b0, NO_LINE}
  };

  localparam logic [HEIGHT_W-1:0] PHASE_HEIGHT [PHASES] = '{
    6'd63, 6'd0, 6'd1, 6'd63, 6'd17, 6'd2, 6'd40, 6'd31
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  nrsc_span_if span_ch ();
  nrsc_line_if line_ch ();

  note_row_span_coalescer dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_span  (span_ch),
    .out_line (line_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk_i = ~clk_i;

  // predictor state: one pending span per row
  logic                  row_busy [MAX_ROWS];
  logic [PIXEL_BITS-1:0] row_lo [MAX_ROWS];
  logic [PIXEL_BITS-1:0] row_hi [MAX_ROWS];
  logic [HEIGHT_W-1:0]   cur_height;

  line_t lines_new[$];
  line_t lines_due[$];

  int errors;
  int n_in;
  int n_out;
  int cycles;
  int gap_pct;
  int stall_pct;
  logic [NOTE_W-1:0]     note_pool [4];
  logic [PIXEL_BITS-1:0] note_cursor [4];

  task automatic report(input string msg);
    errors++;
    if (errors <= 30) $display("mismatch: %s", msg);
  endtask

  // one step of the row coalescing, lines caused land in lines_new
  function automatic void merge_rows(input span_item_t it);
    int unsigned up, row, hh, lo, hi, s, e;
    line_t ln;
    lines_new.delete();
    hh = 32'(cur_height);
    case (it.func)
      FUNC_SPAN: begin
        up  = (32'(it.note) * hh + NOTE_COUNT - 1) / NOTE_COUNT;
        row = (up > hh) ? 0 : hh - up;
        s   = 32'(it.s);
        e   = 32'(it.e);
        if (row < MAX_ROWS) begin
          lo = 32'(row_lo[row]);
          hi = 32'(row_hi[row]);
          if (!row_busy[row]) begin
            row_busy[row] = 1'b1;
            row_lo[row]   = PIXEL_BITS'(s);
            row_hi[row]   = PIXEL_BITS'(e);
          end else if (!(hi + 1 < s) && !(lo > e + 1)) begin
            row_lo[row] = PIXEL_BITS'((s < lo) ? s : lo);
            row_hi[row] = PIXEL_BITS'((e > hi) ? e : hi);
          end else begin
            ln = '{row[HEIGHT_W-1:0], row_lo[row], row_hi[row], 1'b1};
            lines_new.push_back(ln);
            row_lo[row] = PIXEL_BITS'(s);
            row_hi[row] = PIXEL_BITS'(e);
          end
        end
      end
      FUNC_CLEAR: begin
        for (int k = 0; k < MAX_ROWS; k++) row_busy[k] = 1'b0;
      end
      FUNC_FLUSH: begin
        for (int k = 0; k <= hh && k < MAX_ROWS; k++) begin
          if (row_busy[k]) begin
            ln = '{k[HEIGHT_W-1:0], row_lo[k], row_hi[k], 1'b0};
            lines_new.push_back(ln);
          end
        end
        if (lines_new.size() > 0) lines_new[lines_new.size()-1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // mostly spans on a few notes that keep running along the row, so they merge
  // or replace; the rest is clears, flushes, unused codes and stray spans
  function automatic span_item_t gen_item();
    span_item_t it;
    int r, k, kind;
    it = '{FUNC_W'($urandom_range(0, 3)), NOTE_W'($urandom_range(0, 127)),
           PIXEL_BITS'($urandom), PIXEL_BITS'($urandom)};
    r  = $urandom_range(0, 99);
    if (r < 4) it.func = FUNC_UNUSED;
    else if (r < 9) it.func = FUNC_CLEAR;
    else if (r < 19) it.func = FUNC_FLUSH;
    else begin
      it.func = FUNC_SPAN;
      k    = $urandom_range(0, 3);
      kind = $urandom_range(0, 9);
      if (kind != 0) it.note = note_pool[k];
      if (kind == 1) begin
        it.s = PIXEL_BITS'($urandom_range(0, 1) ? 16'hFFFF - $urandom_range(0, 3)
                                                : $urandom_range(0, 3));
        it.e = PIXEL_BITS'($urandom_range(0, 1) ? 16'hFFFF - $urandom_range(0, 3)
                                                : $urandom_range(0, 3));
      end else if (kind > 2) begin
        it.s = PIXEL_BITS'(note_cursor[k] + $urandom_range(0, 3));
        it.e = PIXEL_BITS'(it.s + $urandom_range(0, 40));
        note_cursor[k] = it.e;
      end
    end
    return it;
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_item(input span_item_t it, input bit typed, input bit has_line,
                           input line_t want);
    while ($urandom_range(0, 99) < gap_pct) begin
      span_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    span_ch.valid      <= 1'b1;
    span_ch.func       <= it.func;
    span_ch.note       <= it.note;
    span_ch.span_start <= it.s;
    span_ch.span_end   <= it.e;
    @(posedge clk_i);
    while (!span_ch.ready) @(posedge clk_i);
    n_in++;
    merge_rows(it);
    if (typed) begin
      if (has_line) lines_due.push_back(want);
    end else begin
      foreach (lines_new[i]) lines_due.push_back(lines_new[i]);
    end
    @(negedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_HEIGHT, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_height(input logic [HEIGHT_W-1:0] h);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd[HEIGHT_W-1:0] !== h) report($sformatf("height reads %0d, want %0d", rd, h));
  endtask

  task automatic set_height(input logic [HEIGHT_W-1:0] h);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b1, PDATA_W'(h), rd);
    cur_height = h;
    check_height(h);
  endtask

  task automatic wait_drained();
    while (lines_due.size() != 0) @(posedge clk_i);
    // a flush with nothing valid still walks the rows
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) line_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk_i) begin : line_check
    line_t got, want;
    if (line_ch.valid && line_ch.ready) begin
      got = '{line_ch.line_row, line_ch.line_start, line_ch.line_end, line_ch.last};
      n_out++;
      if (lines_due.size() == 0) begin
        report($sformatf("unexpected line row %0d %0d..%0d", got.row, got.lo, got.hi));
      end else begin
        want = lines_due.pop_front();
        if (got.row !== want.row)
          report($sformatf("line %0d row %0d, want %0d", n_out, got.row, want.row));
        if (got.lo !== want.lo)
          report($sformatf("line %0d start %0d, want %0d", n_out, got.lo, want.lo));
        if (got.hi !== want.hi)
          report($sformatf("line %0d end %0d, want %0d", n_out, got.hi, want.hi));
        if (got.last !== want.last)
          report($sformatf("line %0d last %0d, want %0d", n_out, got.last, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d lines outstanding", cycles, lines_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    span_ch.valid      = 1'b0;
    span_ch.func       = FUNC_SPAN;
    span_ch.note       = '0;
    span_ch.span_start = '0;
    span_ch.span_end   = '0;
    line_ch.ready      = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    errors             = 0;
    n_in               = 0;
    n_out              = 0;
    cycles             = 0;
    gap_pct            = 0;
    stall_pct          = 0;
    cur_height         = HEIGHT_RESET;
    for (int k = 0; k < MAX_ROWS; k++) begin
      row_busy[k] = 1'b0;
      row_lo[k]   = '0;
      row_hi[k]   = '0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    check_height(HEIGHT_RESET);
    for (int i = 0; i < DIR_N; i++)
      send_item(DIR_TBL[i].item, DIR_TBL[i].typed, DIR_TBL[i].has_line, DIR_TBL[i].want);
    span_ch.valid <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_height(PHASE_HEIGHT[ph]);
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 50; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 50; end
        default: begin gap_pct = 10; stall_pct = 10; end
      endcase
      for (int k = 0; k < 4; k++) begin
        note_pool[k]   = NOTE_W'($urandom_range(0, 127));
        note_cursor[k] = PIXEL_BITS'($urandom);
      end
      note_pool[0] = ph[0] ? 7'd127 : 7'd0;
      repeat (PHASE_ITEMS) send_item(gen_item(), 1'b0, 1'b0, NO_LINE);
      span_ch.valid <= 1'b0;
      wait_drained();
    end

    $display("%0d input transactions, %0d line transactions checked", n_in, n_out);
    $display("heights 0, 1, 2, 17, 31, 40 and 63 under four idle and stall mixes");
    if (errors == 0 && lines_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== note_row_span_coalescer.f =====
rtl/nrsc_pkg.sv
rtl/nrsc_span_if.sv
rtl/nrsc_line_if.sv
rtl/nrsc_ram.sv
rtl/nrsc_cfg.sv
rtl/nrsc_ctrl.sv
rtl/note_row_span_coalescer.sv
sim/tb_note_row_span_coalescer.sv
